### rtl/core/bsetc_pkg.sv
// ----------------------------------------------------------------------------
// bsetc_pkg
// Shared types and constants for the box set exact tiling check.
// ----------------------------------------------------------------------------
package bsetc_pkg;

  // Port-level field widths (fixed by the word format)
  localparam int NUM_FIELD_DIMS = 4;
  localparam int OFFSET_IN_W    = 12;
  localparam int EXTENT_IN_W    = 13;
  localparam int CFG_W          = 3;

  // Volumes saturate at 2^VOL_W - 1
  localparam int              VOL_W   = 56;
  localparam int              HALF_W  = VOL_W / 2;
  localparam logic [VOL_W-1:0] VOL_CAP = '1;

  localparam logic [CFG_W-1:0] DIMS_RESET = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VOL_LO,
    ST_VOL_HI,
    ST_SUM,
    ST_SCAN,
    ST_DRAIN,
    ST_STORE,
    ST_BV_LO,
    ST_BV_HI,
    ST_DONE
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, update bounds
    logic mul_init;  // product = 1, dimension = 0
    logic mul_lo;    // low half partial product
    logic mul_hi;    // high half partial product, combine, saturate
    logic mul_span;  // multiply by bounding span instead of box extent
    logic add_vol;   // add box volume into running sum
    logic scan_rd;   // read next stored box
    logic store;     // write box into store or flag overflow
    logic finish;    // load result, clear set state
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dim_last;
    logic empty;
    logic cnt_zero;
    logic scan_last;
    logic last_box;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/bsetc_ram.sv
// ----------------------------------------------------------------------------
// bsetc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsetc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bsetc_ctrl.sv
// ----------------------------------------------------------------------------
// bsetc_ctrl
// Sequencer: volume product, sum, overlap scan, store, bounding volume, result.
// ----------------------------------------------------------------------------
module bsetc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsetc_pkg::dp_stat_t stat,
  output bsetc_pkg::dp_cmd_t  cmd
);
  import bsetc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.mul_init = 1'b1;
          state_nxt    = ST_VOL_LO;
        end
      end
      ST_VOL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_VOL_HI;
      end
      ST_VOL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = stat.dim_last ? ST_SUM : ST_VOL_LO;
      end
      ST_SUM: begin
        cmd.add_vol = 1'b1;
        state_nxt   = (stat.empty || stat.cnt_zero) ? ST_STORE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word is compared on this cycle
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (stat.last_box) begin
          cmd.mul_init = 1'b1;
          state_nxt    = ST_BV_LO;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BV_LO: begin
        cmd.mul_lo   = 1'b1;
        cmd.mul_span = 1'b1;
        state_nxt    = ST_BV_HI;
      end
      ST_BV_HI: begin
        cmd.mul_hi   = 1'b1;
        cmd.mul_span = 1'b1;
        state_nxt    = stat.dim_last ? ST_DONE : ST_BV_LO;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/bsetc_dpath.sv
// ----------------------------------------------------------------------------
// bsetc_dpath
// Box registers, bounds, shared saturating multiplier, box store and result.
// ----------------------------------------------------------------------------
module bsetc_dpath #(
  parameter int MAX_BOXES  = 64,
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bsetc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [bsetc_pkg::OFFSET_IN_W-1:0] in_offset [bsetc_pkg::NUM_FIELD_DIMS],
  input  logic [bsetc_pkg::EXTENT_IN_W-1:0] in_extent [bsetc_pkg::NUM_FIELD_DIMS],
  input  logic                              in_last_box,
  input  bsetc_pkg::dp_cmd_t                cmd,
  output bsetc_pkg::dp_stat_t               stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_is_exact_tiling,
  output logic                              out_store_overflow
);
  import bsetc_pkg::*;

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int ENT_W  = COORD_BITS + SPAN_W;
  localparam int WORD_W = MAX_DIMS * ENT_W;
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int ADDR_W = $clog2(MAX_BOXES);
  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PLO_W  = HALF_W + SPAN_W;
  localparam int PROD_W = VOL_W + SPAN_W;
  localparam logic [31:0]           EXT_MAX  = 32'd1 << COORD_BITS;
  localparam logic [CNT_W-1:0]      CNT_FULL = CNT_W'(MAX_BOXES);
  localparam logic [CFG_W-1:0]      ND_MAX   = CFG_W'(MAX_DIMS);

  // configuration and item registers
  logic [CFG_W-1:0]      dims_r;
  logic [CFG_W-1:0]      nd_r;
  logic [COORD_BITS-1:0] off_r [MAX_DIMS];
  logic [SPAN_W-1:0]     ext_r [MAX_DIMS];
  logic                  last_r;
  logic                  empty_r;

  // set state
  logic [COORD_BITS-1:0] blo_r [MAX_DIMS];
  logic [SPAN_W-1:0]     bhi_r [MAX_DIMS];
  logic [VOL_W-1:0]      vsum_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  ovl_r;
  logic                  ovf_r;

  // multiplier and scan
  logic [VOL_W-1:0]      vol_r;
  logic [PLO_W-1:0]      plo_r;
  logic [DIM_W-1:0]      dim_r;
  logic [CNT_W-1:0]      k_r;
  logic                  cmp_vld_r;

  logic                  out_valid_r;
  logic                  out_exact_r;
  logic                  out_ovf_r;

  logic [CFG_W-1:0]      nd_in;
  logic [COORD_BITS-1:0] off_in [MAX_DIMS];
  logic [SPAN_W-1:0]     ext_in [MAX_DIMS];
  logic [SPAN_W-1:0]     end_in [MAX_DIMS];
  logic                  empty_in;
  logic [SPAN_W-1:0]     span   [MAX_DIMS];
  logic [HALF_W-1:0]     mul_a;
  logic [SPAN_W-1:0]     mul_b;
  logic [PLO_W-1:0]      prod;
  logic [PROD_W-1:0]     full;
  logic [VOL_W-1:0]      vol_new;
  logic [VOL_W:0]        vsum_wide;
  logic [WORD_W-1:0]     wr_word;
  logic [WORD_W-1:0]     rd_word;
  logic                  hit;
  logic                  store_en;

  // dims: zero acts as one, above MAX_DIMS clamps
  always_comb begin
    if (dims_r == '0) begin
      nd_in = CFG_W'(1);
    end else if (dims_r > ND_MAX) begin
      nd_in = ND_MAX;
    end else begin
      nd_in = dims_r;
    end
  end

  always_comb begin
    logic [31:0] e32;
    empty_in = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      e32       = 32'(in_extent[d]);
      off_in[d] = COORD_BITS'(32'(in_offset[d]));
      ext_in[d] = (e32 > EXT_MAX) ? SPAN_W'(EXT_MAX) : SPAN_W'(e32);
      end_in[d] = SPAN_W'(off_in[d]) + ext_in[d];
      if (d < int'(nd_in) && ext_in[d] == '0) begin
        empty_in = 1'b1;
      end
      span[d] = (bhi_r[d] > SPAN_W'(blo_r[d])) ? (bhi_r[d] - SPAN_W'(blo_r[d])) : '0;
    end
  end

  // shared multiplier: 28-bit half of the product times one extent or span
  assign mul_a   = cmd.mul_hi ? vol_r[VOL_W-1:HALF_W] : vol_r[HALF_W-1:0];
  assign mul_b   = cmd.mul_span ? span[dim_r] : ext_r[dim_r];
  assign prod    = PLO_W'(mul_a) * PLO_W'(mul_b);
  assign full    = {prod, {HALF_W{1'b0}}} + PROD_W'(plo_r);
  assign vol_new = (|full[PROD_W-1:VOL_W]) ? VOL_CAP : full[VOL_W-1:0];

  assign vsum_wide = {1'b0, vsum_r} + {1'b0, vol_r};

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      wr_word[d*ENT_W +: COORD_BITS]          = off_r[d];
      wr_word[d*ENT_W + COORD_BITS +: SPAN_W] = ext_r[d];
    end
  end

  // overlap of the held box with one stored box
  always_comb begin
    logic [COORD_BITS-1:0] so;
    logic [SPAN_W-1:0]     se;
    logic [SPAN_W:0]       n_end;
    logic [SPAN_W:0]       s_end;
    hit = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      so    = rd_word[d*ENT_W +: COORD_BITS];
      se    = rd_word[d*ENT_W + COORD_BITS +: SPAN_W];
      n_end = (SPAN_W+1)'(off_r[d]) + (SPAN_W+1)'(ext_r[d]);
      s_end = (SPAN_W+1)'(so) + (SPAN_W+1)'(se);
      if (d < int'(nd_r) &&
          (se == '0 || n_end <= (SPAN_W+1)'(so) || (SPAN_W+1)'(off_r[d]) >= s_end)) begin
        hit = 1'b0;
      end
    end
  end

  assign store_en = cmd.store && (cnt_r < CNT_FULL);

  bsetc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (wr_word),
    .re    (cmd.scan_rd),
    .raddr (k_r[ADDR_W-1:0]),
    .rdata (rd_word)
  );

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nd_r    <= nd_in;
      last_r  <= in_last_box;
      empty_r <= empty_in;
      for (int d = 0; d < MAX_DIMS; d++) begin
        off_r[d] <= off_in[d];
        ext_r[d] <= ext_in[d];
      end
    end
    if (cmd.mul_init) begin
      vol_r <= VOL_W'(1);
    end else if (cmd.mul_hi) begin
      vol_r <= vol_new;
    end
    if (cmd.mul_lo) begin
      plo_r <= prod;
    end
  end

  // control and set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r      <= DIMS_RESET;
      vsum_r      <= '0;
      cnt_r       <= '0;
      ovl_r       <= 1'b0;
      ovf_r       <= 1'b0;
      dim_r       <= '0;
      k_r         <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        blo_r[d] <= '1;
        bhi_r[d] <= '0;
      end
    end else begin
      if (cfg_we) begin
        dims_r <= cfg_wdata;
      end
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.load) begin
        k_r <= '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
          if (d < int'(nd_in)) begin
            if (off_in[d] < blo_r[d]) blo_r[d] <= off_in[d];
            if (end_in[d] > bhi_r[d]) bhi_r[d] <= end_in[d];
          end
        end
      end
      if (cmd.mul_init) begin
        dim_r <= '0;
      end else if (cmd.mul_hi) begin
        dim_r <= dim_r + DIM_W'(1);
      end
      if (cmd.add_vol) begin
        vsum_r <= vsum_wide[VOL_W] ? VOL_CAP : vsum_wide[VOL_W-1:0];
      end
      if (cmd.scan_rd) begin
        k_r <= k_r + CNT_W'(1);
      end
      if (cmp_vld_r && hit) begin
        ovl_r <= 1'b1;
      end
      if (cmd.store) begin
        if (store_en) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      // a new result only loads once the old one is taken
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        vsum_r      <= '0;
        cnt_r       <= '0;
        ovl_r       <= 1'b0;
        ovf_r       <= 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
          blo_r[d] <= '1;
          bhi_r[d] <= '0;
        end
      end
    end
  end

  // result word; vol_r holds the bounding volume here
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_exact_r <= !ovf_r && !ovl_r && (vsum_r == vol_r);
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_exact_tiling = out_exact_r;
  assign out_store_overflow  = out_ovf_r;

  assign stat.dim_last  = (CFG_W'(dim_r) == nd_r - CFG_W'(1));
  assign stat.empty     = empty_r;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.scan_last = (k_r == cnt_r - CNT_W'(1));
  assign stat.last_box  = last_r;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

### rtl/core/box_set_exact_tiling_check_top.sv
// ----------------------------------------------------------------------------
// box_set_exact_tiling_check_top
// Checks whether a stream of axis-aligned boxes tiles its bounding box exactly.
// ----------------------------------------------------------------------------
// Each input word is one box (offset and extent in up to four dimensions, of
// which the first cfg dims are compared); the word flagged last_box closes the
// set and yields one result word (exact tiling, store overflow), after which
// the set state clears. A box holds the input while its volume is formed, then
// while it is checked for overlap when it is non-empty and boxes are already
// stored (one stored box read and compared per cycle through the single read
// port of the box store); the last box of a set also forms the bounding
// volume. Volumes run through one shared 28-bit by extent or span multiplier,
// a low-half and a high-half step per dimension. The box store has no reset
// and needs no clearing pass: only entries written in the current set are
// read. A result waiting on out_ready does not block the next boxes; only a
// second closing box waits until the first result is taken.
// Write the dims register only while the block is idle.
// ----------------------------------------------------------------------------
module box_set_exact_tiling_check_top #(
  parameter int MAX_BOXES  = 64,
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // dims register write
  input  logic                              cfg_we,
  input  logic [bsetc_pkg::CFG_W-1:0]       cfg_wdata,
  // box words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsetc_pkg::OFFSET_IN_W-1:0] in_offset_0,
  input  logic [bsetc_pkg::OFFSET_IN_W-1:0] in_offset_1,
  input  logic [bsetc_pkg::OFFSET_IN_W-1:0] in_offset_2,
  input  logic [bsetc_pkg::OFFSET_IN_W-1:0] in_offset_3,
  input  logic [bsetc_pkg::EXTENT_IN_W-1:0] in_extent_0,
  input  logic [bsetc_pkg::EXTENT_IN_W-1:0] in_extent_1,
  input  logic [bsetc_pkg::EXTENT_IN_W-1:0] in_extent_2,
  input  logic [bsetc_pkg::EXTENT_IN_W-1:0] in_extent_3,
  input  logic                              in_last_box,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_is_exact_tiling,
  output logic                              out_store_overflow
);
  import bsetc_pkg::*;

  logic [OFFSET_IN_W-1:0] offset_arr [NUM_FIELD_DIMS];
  logic [EXTENT_IN_W-1:0] extent_arr [NUM_FIELD_DIMS];
  dp_cmd_t                cmd;
  dp_stat_t               stat;

  // dimension fields as arrays; the datapath uses the first MAX_DIMS
  assign offset_arr[0] = in_offset_0;
  assign offset_arr[1] = in_offset_1;
  assign offset_arr[2] = in_offset_2;
  assign offset_arr[3] = in_offset_3;
  assign extent_arr[0] = in_extent_0;
  assign extent_arr[1] = in_extent_1;
  assign extent_arr[2] = in_extent_2;
  assign extent_arr[3] = in_extent_3;

  // sequencer
  bsetc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bounds, volumes, box store, result register
  bsetc_dpath #(
    .MAX_BOXES  (MAX_BOXES),
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_offset           (offset_arr),
    .in_extent           (extent_arr),
    .in_last_box         (in_last_box),
    .cmd                 (cmd),
    .stat                (stat),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_is_exact_tiling (out_is_exact_tiling),
    .out_store_overflow  (out_store_overflow)
  );

endmodule
